// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker of the penalty score table.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NPS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed at a response transaction");

// The consequent must hold in the cycle after the antecedent.
`define NPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed one cycle after a stalled response");

`endif

// File: src/nps_pkg.sv
// ----------------------------------------------------------------------------
// nps_pkg
// Types, codes and defaults of the node penalty score table.
// ----------------------------------------------------------------------------
package nps_pkg;

  localparam int NODE_COUNT_DEF  = 256;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam logic [7:0]  WITHHOLD_RST  = 8'd5;
  localparam logic [7:0]  ABSTAIN_RST   = 8'd2;
  localparam logic [7:0]  INVALID_RST   = 8'd10;
  localparam logic [15:0] THRESHOLD_RST = 16'd100;

  localparam logic [2:0] CMD_WITHHOLD = 3'd0;
  localparam logic [2:0] CMD_ABSTAIN  = 3'd1;
  localparam logic [2:0] CMD_INVALID  = 3'd2;
  localparam logic [2:0] CMD_HONEST   = 3'd3;
  localparam logic [2:0] CMD_READ     = 3'd4;
  localparam logic [2:0] CMD_ADVANCE  = 3'd5;

  typedef enum logic [1:0] {
    REG_WITHHOLD  = 2'd0,
    REG_ABSTAIN   = 2'd1,
    REG_INVALID   = 2'd2,
    REG_THRESHOLD = 2'd3
  } cfg_reg_e_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] node_index;
  } cmd_t;

  typedef struct packed {
    logic [15:0] node_score;
    logic        node_eligible;
    logic [15:0] node_tickets;
    logic        node_window_zeroed;
    logic        top_valid;
    logic [7:0]  lead_node;
    logic [15:0] lead_tickets;
  } rsp_t;

endpackage

// File: src/node_penalty_score_table_core.sv
// ----------------------------------------------------------------------------
// node_penalty_score_table_core
// Per-node penalty score, eligibility and ticket table with window advance.
// ----------------------------------------------------------------------------
// Commands arrive on the cmd channel (cmd_valid, cmd_stall, cmd_data) and each
// transaction produces exactly one response on the rsp channel (rsp_valid,
// rsp_stall, rsp_data). Configuration registers are written over the cfg
// channel, which is always ready and should only be used while the block is
// idle.
// The records live in one RAM with a registered read. A record command passes
// through read, modify and write back, then hand-off to the response
// register. An advance walks the whole RAM, one entry per cycle.
// The response register decouples the two channels: a new command is taken
// while an earlier response still waits. When the receiver stalls and the
// response register is full, the finished result waits and cmd_stall stays
// high.
// After reset the RAM is cleared one entry per cycle; cmd_stall is high
// during that pass and configuration writes are still taken.
// ----------------------------------------------------------------------------
module node_penalty_score_table_core #(
  parameter int NODE_COUNT  = nps_pkg::NODE_COUNT_DEF,
  parameter int COUNT_WIDTH = nps_pkg::COUNT_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  nps_pkg::cmd_t cmd_data,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output nps_pkg::rsp_t rsp_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [15:0]   cfg_data
);

  localparam int AW   = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int CW   = COUNT_WIDTH;
  localparam int RW   = 2 * CW + 2;
  localparam int CMPW = 33;
  localparam logic [AW-1:0] LAST_ADDR = AW'(NODE_COUNT - 1);

  nps_pkg::state_t state, state_next;

  logic [7:0]    withhold_penalty;
  logic [7:0]    abstain_penalty;
  logic [7:0]    invalid_penalty;
  logic [15:0]   score_threshold;

  logic [2:0]    cmd_q;
  logic          hit_q;
  logic [AW-1:0] addr_q;
  logic [AW-1:0] sweep_addr;
  logic [CW-1:0] best;
  logic [AW-1:0] best_idx;
  nps_pkg::rsp_t res;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [RW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [RW-1:0] ram_rdata;

  logic [CW-1:0] r_score;
  logic [CW-1:0] r_tickets;
  logic          r_elig;
  logic          r_mark;

  logic [7:0]    pen_amt;
  logic [CW:0]   pen_sum;
  logic [CW-1:0] new_score;
  logic [CW-1:0] new_tickets;
  logic          new_elig;
  logic          new_mark;

  logic          cmd_fire;
  logic          rsp_free;
  logic          sweep_last;
  logic [CW-1:0] best_next;
  logic [AW-1:0] best_idx_next;
  nps_pkg::rsp_t res_next;

  assign cfg_ready = 1'b1;
  assign cmd_stall = (state != nps_pkg::ST_IDLE);
  assign cmd_fire  = cmd_valid && !cmd_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;

  assign r_score   = ram_rdata[2*CW+1:CW+2];
  assign r_tickets = ram_rdata[CW+1:2];
  assign r_elig    = ram_rdata[1];
  assign r_mark    = ram_rdata[0];

  nps_ram #(
    .WIDTH(RW),
    .DEPTH(NODE_COUNT)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Record update for penalty and honest commands.
  always_comb begin
    case (cmd_q)
      nps_pkg::CMD_WITHHOLD: pen_amt = withhold_penalty;
      nps_pkg::CMD_ABSTAIN:  pen_amt = abstain_penalty;
      default:               pen_amt = invalid_penalty;
    endcase
    pen_sum     = {1'b0, r_score} + (CW+1)'(pen_amt);
    new_score   = r_score;
    new_tickets = r_tickets;
    new_elig    = r_elig;
    new_mark    = r_mark;
    if (cmd_q inside {nps_pkg::CMD_WITHHOLD, nps_pkg::CMD_ABSTAIN, nps_pkg::CMD_INVALID}) begin
      new_score   = pen_sum[CW] ? {CW{1'b1}} : pen_sum[CW-1:0];
      new_tickets = '0;
      new_mark    = 1'b1;
      if (CMPW'(new_score) >= CMPW'(score_threshold)) begin
        new_elig = 1'b0;
      end
    end else if (cmd_q == nps_pkg::CMD_HONEST) begin
      if (!r_mark && (r_tickets != {CW{1'b1}})) begin
        new_tickets = r_tickets + CW'(1);
      end
      if (r_score != '0) begin
        new_score = r_score - CW'(1);
        if (CMPW'(new_score) < CMPW'(score_threshold)) begin
          new_elig = 1'b1;
        end
      end
    end
  end

  // Sequencer: RAM port control, sweep bookkeeping and result assembly.
  always_comb begin
    state_next    = state;
    ram_we        = 1'b0;
    ram_waddr     = sweep_addr;
    ram_wdata     = {{CW{1'b0}}, {CW{1'b0}}, 1'b1, 1'b0};
    ram_raddr     = sweep_addr + AW'(1);
    sweep_last    = (sweep_addr == LAST_ADDR);
    best_next     = best;
    best_idx_next = best_idx;
    res_next      = res;
    if (r_tickets > best) begin
      best_next     = r_tickets;
      best_idx_next = sweep_addr;
    end
    case (state)
      nps_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
        if (sweep_last) begin
          state_next = nps_pkg::ST_IDLE;
        end
      end
      nps_pkg::ST_IDLE: begin
        if (cmd_data.cmd == nps_pkg::CMD_ADVANCE) begin
          ram_raddr = '0;
        end else begin
          ram_raddr = AW'(cmd_data.node_index);
        end
        if (cmd_fire) begin
          if (cmd_data.cmd == nps_pkg::CMD_ADVANCE) begin
            state_next = nps_pkg::ST_SWEEP;
          end else begin
            state_next = nps_pkg::ST_EXEC;
          end
        end
      end
      nps_pkg::ST_EXEC: begin
        ram_we    = hit_q;
        ram_waddr = addr_q;
        ram_wdata = {new_score, new_tickets, new_elig, new_mark};
        res_next  = '0;
        if (hit_q) begin
          res_next.node_score         = 16'(new_score);
          res_next.node_eligible      = new_elig;
          res_next.node_tickets       = 16'(new_tickets);
          res_next.node_window_zeroed = new_mark;
        end else begin
          res_next.node_eligible = 1'b1;
        end
        state_next = nps_pkg::ST_DONE;
      end
      nps_pkg::ST_SWEEP: begin
        ram_we    = 1'b1;
        ram_wdata = {r_score, {CW{1'b0}}, r_elig, 1'b0};
        if (sweep_last) begin
          res_next              = '0;
          res_next.top_valid    = (best_next != '0);
          res_next.lead_node    = 8'(best_idx_next);
          res_next.lead_tickets = 16'(best_next);
          state_next            = nps_pkg::ST_DONE;
        end
      end
      nps_pkg::ST_DONE: begin
        if (rsp_free) begin
          state_next = nps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = nps_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= nps_pkg::ST_CLEAR;
      sweep_addr       <= '0;
      rsp_valid        <= 1'b0;
      withhold_penalty <= nps_pkg::WITHHOLD_RST;
      abstain_penalty  <= nps_pkg::ABSTAIN_RST;
      invalid_penalty  <= nps_pkg::INVALID_RST;
      score_threshold  <= nps_pkg::THRESHOLD_RST;
    end else begin
      state <= state_next;
      if (state == nps_pkg::ST_CLEAR || state == nps_pkg::ST_SWEEP) begin
        sweep_addr <= sweep_addr + AW'(1);
      end else if (cmd_fire) begin
        sweep_addr <= '0;
      end
      if (state == nps_pkg::ST_DONE && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          nps_pkg::REG_WITHHOLD:  withhold_penalty <= cfg_data[7:0];
          nps_pkg::REG_ABSTAIN:   abstain_penalty  <= cfg_data[7:0];
          nps_pkg::REG_INVALID:   invalid_penalty  <= cfg_data[7:0];
          nps_pkg::REG_THRESHOLD: score_threshold  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      cmd_q    <= cmd_data.cmd;
      hit_q    <= (32'(cmd_data.node_index) < NODE_COUNT);
      addr_q   <= AW'(cmd_data.node_index);
      best     <= '0;
      best_idx <= '0;
    end else if (state == nps_pkg::ST_SWEEP) begin
      best     <= best_next;
      best_idx <= best_idx_next;
    end
    res <= res_next;
    if (state == nps_pkg::ST_DONE && rsp_free) begin
      rsp_data <= res;
    end
  end

endmodule

// File: src/nps_ram.sv
// ----------------------------------------------------------------------------
// nps_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module nps_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 256
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/nps_checker.sv
// ----------------------------------------------------------------------------
// nps_checker
// Port-level checks of the response channel of the penalty score table.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nps_checker (
  input logic          clk,
  input logic          rst,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input nps_pkg::rsp_t rsp_data
);

  logic rec_zero;
  logic lead_zero;
  logic lead_nonzero;
  logic no_tickets;

  assign rec_zero     = (rsp_data.node_score == 16'd0) && !rsp_data.node_eligible &&
                        (rsp_data.node_tickets == 16'd0) && !rsp_data.node_window_zeroed;
  assign lead_zero    = (rsp_data.lead_node == 8'd0) && (rsp_data.lead_tickets == 16'd0);
  assign lead_nonzero = (rsp_data.lead_tickets != 16'd0);
  assign no_tickets   = (rsp_data.node_tickets == 16'd0);

  `NPS_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))
  `NPS_ASSERT_NOW(a_top_record_zero, clk, rst, rsp_valid && rsp_data.top_valid, rec_zero)
  `NPS_ASSERT_NOW(a_top_idle_zero, clk, rst, rsp_valid && !rsp_data.top_valid, lead_zero)
  `NPS_ASSERT_NOW(a_top_has_tickets, clk, rst, rsp_valid && rsp_data.top_valid, lead_nonzero)
  `NPS_ASSERT_NOW(a_marked_no_tickets, clk, rst, rsp_valid && rsp_data.node_window_zeroed, no_tickets)

endmodule

bind node_penalty_score_table_core nps_checker u_nps_checker (
  .clk      (clk),
  .rst      (rst),
  .rsp_valid(rsp_valid),
  .rsp_stall(rsp_stall),
  .rsp_data (rsp_data)
);
